// File: hw/rtl/fp32_to_fp8_quantizer_core_assert.svh
// ----------------------------------------------------------------------------
// fp32_to_fp8_quantizer_core assertion macros
// Shared assertion forms, clocked on clk_i and disabled during rst_ni low.
// ----------------------------------------------------------------------------
`ifndef FP32_TO_FP8_QUANTIZER_CORE_ASSERT_SVH
`define FP32_TO_FP8_QUANTIZER_CORE_ASSERT_SVH

// same-cycle implication
`define FP8Q_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fp8q assertion failed");

// next-cycle implication
`define FP8Q_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fp8q assertion failed");

`endif

// File: hw/rtl/fp8q_pkg.sv
// ----------------------------------------------------------------------------
// fp8q_pkg
// Widths, format codes and fixed FP8 code constants of the FP32 to FP8 block.
// ----------------------------------------------------------------------------
package fp8q_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CodeW  = 8;

  typedef enum logic {
    FMT_E4M3 = 1'b0,
    FMT_E5M2 = 1'b1
  } fmt_e;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [CodeW-1:0]  code_t;

  localparam code_t      CodeNan     = 8'h7F;
  localparam logic [6:0] SatE4m3     = 7'h7E;
  localparam logic [6:0] SatE5m2     = 7'h7C;

endpackage

// File: hw/rtl/fp8q_if.sv
// ----------------------------------------------------------------------------
// fp8q channel interfaces
// Valid/ready channels for FP32 input requests, FP8 results and format writes.
// ----------------------------------------------------------------------------
interface fp8q_in_if;
  logic             valid;
  logic             ready;
  fp8q_pkg::value_t value_bits;

  modport source (output valid, output value_bits, input ready);
  modport sink   (input valid, input value_bits, output ready);
endinterface

interface fp8q_out_if;
  logic            valid;
  logic            ready;
  fp8q_pkg::code_t fp8_code;

  modport source (output valid, output fp8_code, input ready);
  modport sink   (input valid, input fp8_code, output ready);
endinterface

interface fp8q_cfg_if;
  logic valid;
  logic ready;
  logic format_select;

  modport source (output valid, output format_select, input ready);
  modport sink   (input valid, input format_select, output ready);
endinterface

// File: hw/rtl/fp8q_convert.sv
// ----------------------------------------------------------------------------
// fp8q_convert
// Combinational FP32 to FP8 (E4M3 or E5M2) conversion of one bit pattern.
// ----------------------------------------------------------------------------
module fp8q_convert (
  input  fp8q_pkg::value_t value_bits_i,
  input  fp8q_pkg::fmt_e   fmt_i,
  output fp8q_pkg::code_t  fp8_code_o
);

  logic              sgn;
  logic [7:0]        ef;
  logic [22:0]       mant;
  logic              e5;
  logic signed [9:0] te;
  logic signed [9:0] bias_off;
  logic signed [9:0] top;
  logic signed [9:0] low_lim;
  logic signed [9:0] sh_base;
  logic signed [9:0] sh_full;
  logic [4:0]        sh;
  logic [24:0]       rnd;
  logic [24:0]       sub_sum;
  logic [24:0]       sub_shift;
  logic [3:0]        m;
  logic [3:0]        m_lim;
  logic [6:0]        sat;
  logic [3:0]        tm4;
  logic [2:0]        tm3;
  logic              carry;
  logic signed [9:0] te_n;
  logic [6:0]        norm_mag;

  always_comb begin
    sgn      = value_bits_i[31];
    ef       = value_bits_i[30:23];
    mant     = value_bits_i[22:0];
    e5       = (fmt_i == fp8q_pkg::FMT_E5M2);
    bias_off = e5 ? 10'sd112 : 10'sd120;
    top      = e5 ? 10'sd31 : 10'sd15;
    low_lim  = e5 ? -10'sd2 : -10'sd3;
    sh_base  = e5 ? 10'sd22 : 10'sd21;
    sat      = e5 ? fp8q_pkg::SatE5m2 : fp8q_pkg::SatE4m3;
    m_lim    = e5 ? 4'd4 : 4'd8;
    te       = $signed({2'b00, ef}) - bias_off;

    // below normal range: round half away from zero after scaling
    sh_full   = sh_base - te;
    sh        = sh_full[4:0];
    rnd       = 25'd1 << (sh - 5'd1);
    sub_sum   = {1'b0, 1'b1, mant} + rnd;
    sub_shift = sub_sum >> sh;
    m         = (te < low_lim) ? 4'd0 : sub_shift[3:0];

    // normal range: round up on first dropped bit
    if (e5) begin
      tm4   = {2'b00, mant[22:21]} + {3'b000, mant[20]};
      carry = tm4[2];
      tm3   = {1'b0, tm4[1:0]};
    end else begin
      tm4   = {1'b0, mant[22:20]} + {3'b000, mant[19]};
      carry = tm4[3];
      tm3   = tm4[2:0];
    end
    te_n = te + {9'd0, carry};
    if (e5) begin
      norm_mag = {te_n[4:0], tm3[1:0]};
    end else begin
      norm_mag = {te_n[3:0], tm3};
    end

    if (value_bits_i[30:0] == 31'd0) begin
      fp8_code_o = '0;
    end else if (ef == 8'hFF) begin
      fp8_code_o = (mant != 23'd0) ? fp8q_pkg::CodeNan : {sgn, sat};
    end else if (ef == 8'h00) begin
      fp8_code_o = {sgn, 7'd0};
    end else if (te >= top) begin
      fp8_code_o = {sgn, sat};
    end else if (te <= 10'sd0) begin
      if (m >= m_lim) begin
        fp8_code_o = {sgn, 3'd0, m_lim};
      end else begin
        fp8_code_o = {sgn, 3'd0, m};
      end
    end else if (te_n >= top) begin
      fp8_code_o = {sgn, sat};
    end else begin
      fp8_code_o = {sgn, norm_mag};
    end
  end

endmodule

// File: hw/rtl/fp32_to_fp8_quantizer_core.sv
// ----------------------------------------------------------------------------
// fp32_to_fp8_quantizer_core
// Streaming FP32 to FP8 converter, E4M3 or E5M2 chosen by a format register.
//
// in_i carries one FP32 bit pattern per request; out_o returns one FP8 byte
// per request, in order. cfg_i writes the format register (0 E4M3, 1 E5M2);
// it is always ready; it must be written only while no request is in flight,
// which the user ensures, as the block does not enforce it. The input register
// feeds the conversion logic, whose byte lands in the result register.
// Throughput is one request per cycle while out_o does not stall, set by the
// two register stages, each of which reloads in the cycle it is emptied.
// When out_o stalls, the result register holds its byte and the input
// register still takes one more request; in_i.ready drops only when both
// stages are full. Reset empties both stages and selects E4M3.
// ----------------------------------------------------------------------------
`include "fp32_to_fp8_quantizer_core_assert.svh"

module fp32_to_fp8_quantizer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  fp8q_in_if.sink             in_i,
  fp8q_out_if.source          out_o,
  fp8q_cfg_if.sink            cfg_i
);

  fp8q_pkg::fmt_e   fmt_q;
  logic             s1_valid_q;
  fp8q_pkg::value_t s1_bits_q;
  logic             out_valid_q;
  fp8q_pkg::code_t  out_code_q;
  fp8q_pkg::code_t  conv_code;
  logic             out_load;
  logic             s1_load;
  logic             s1_nan;
  logic             s1_zero;

  assign out_load    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign s1_load     = in_i.valid && in_i.ready;
  assign in_i.ready  = !s1_valid_q || out_load;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.fp8_code = out_code_q;

  assign s1_nan  = (s1_bits_q[30:23] == 8'hFF) && (s1_bits_q[22:0] != 23'd0);
  assign s1_zero = (s1_bits_q[30:0] == 31'd0);

  fp8q_convert u_convert (
    .value_bits_i (s1_bits_q),
    .fmt_i        (fmt_q),
    .fp8_code_o   (conv_code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= fp8q_pkg::FMT_E4M3;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        fmt_q <= fp8q_pkg::fmt_e'(cfg_i.format_select);
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_bits_q <= in_i.value_bits;
    end
    if (out_load) begin
      out_code_q <= conv_code;
    end
  end

  `FP8Q_ASSERT_NEXT(a_s1_hold, s1_valid_q && !out_load, s1_valid_q && $stable(s1_bits_q))
  `FP8Q_ASSERT_NEXT(a_out_fill, out_load, out_valid_q && (out_code_q == $past(conv_code)))
  `FP8Q_ASSERT_NEXT(a_nan_code, out_load && s1_nan, out_code_q == fp8q_pkg::CodeNan)
  `FP8Q_ASSERT_NEXT(a_zero_code, out_load && s1_zero, out_code_q == '0)
  `FP8Q_ASSERT_NOW(a_ready_full, !in_i.ready, s1_valid_q && out_valid_q && !out_o.ready)

endmodule

// File: tb/fp32_to_fp8_quantizer_core_tb.sv
// ----------------------------------------------------------------------------
// fp32_to_fp8_quantizer_core_tb
// Streams FP32 bit patterns through the converter in both E4M3 and E5M2,
// predicts each FP8 byte in a scoreboard and checks results in order. Corner
// values come first, then random values biased toward the FP8 range edges,
// with random idle bursts on the request and result sides.
// ----------------------------------------------------------------------------
module fp32_to_fp8_quantizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 131;
  localparam int unsigned NumCorners    = 13;

  localparam fp8q_pkg::value_t CornerValues [NumCorners] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
    32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h43E8_0000,
    32'hC770_0000, 32'h3FF8_0000, 32'h3C7F_0000, 32'h8000_0001,
    32'hB000_0000
  };

  class fp8_scoreboard;
    fp8q_pkg::code_t pending_codes[$];
    fp8q_pkg::fmt_e  fmt;
    int    mismatches;
    int    accepted;
    int    checked;

    function new();
      fmt        = fp8q_pkg::FMT_E4M3;
      mismatches = 0;
      accepted   = 0;
      checked    = 0;
    endfunction

    function automatic fp8q_pkg::code_t predict_fp8(fp8q_pkg::value_t bits);
      logic [7:0]  efield;
      logic [31:0] mw;
      logic [31:0] sig;
      logic [31:0] rnd;
      logic [31:0] tm;
      logic [6:0]  sat;
      fp8q_pkg::code_t shi;
      int          mb;
      int          bias;
      int          top;
      int          te;
      int          sh;
      efield = bits[30:23];
      mw     = {9'd0, bits[22:0]};
      shi    = {bits[31], 7'd0};
      mb     = (fmt == fp8q_pkg::FMT_E5M2) ? 2 : 3;
      bias   = (fmt == fp8q_pkg::FMT_E5M2) ? 15 : 7;
      top    = (fmt == fp8q_pkg::FMT_E5M2) ? 31 : 15;
      sat    = (fmt == fp8q_pkg::FMT_E5M2) ? fp8q_pkg::SatE5m2 : fp8q_pkg::SatE4m3;
      if (bits[30:0] == '0) return '0;
      if (efield == 8'hFF) return (mw != 0) ? fp8q_pkg::CodeNan : (shi | {1'b0, sat});
      if (efield == 8'h00) return shi;
      te = int'(efield) - 127 + bias;
      if (te >= top) return shi | {1'b0, sat};
      if (te <= 0) begin
        sig = mw | 32'h0080_0000;
        sh  = 24 - mb - te;
        rnd = (sh >= 25) ? 32'd0 : ((sig + (32'd1 << (sh - 1))) >> sh);
        if (rnd == 0) return shi;
        if (rnd >= (32'd1 << mb)) return shi | fp8q_pkg::code_t'(32'd1 << mb);
        return shi | fp8q_pkg::code_t'(rnd);
      end
      tm = mw >> (23 - mb);
      if (mw[22 - mb]) begin
        tm = tm + 1;
        if (tm >= (32'd1 << mb)) begin
          tm = 0;
          te = te + 1;
        end
      end
      if (te >= top) return shi | {1'b0, sat};
      return shi | fp8q_pkg::code_t'((te << mb) | tm);
    endfunction

    function void note_value(fp8q_pkg::value_t bits);
      pending_codes.push_back(predict_fp8(bits));
      accepted++;
    endfunction

    function void check_code(fp8q_pkg::code_t got);
      fp8q_pkg::code_t want;
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: unexpected fp8_code %02h", got);
        return;
      end
      want = pending_codes.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH: fp8_code expected %02h actual %02h (format %s)",
                   want, got, fmt.name());
      end
    endfunction

    function int pending();
      return pending_codes.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idle_en;
  int   stall_cnt;
  int   quiet_cycles;

  fp8_scoreboard sb = new();

  fp8q_in_if  in_if ();
  fp8q_out_if out_if ();
  fp8q_cfg_if cfg_if ();

  fp32_to_fp8_quantizer_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source),
    .cfg_i  (cfg_if.sink)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_if.ready = 1'b0;
    stall_cnt    = 0;
    forever begin
      @(posedge clk_i);
      if (stall_cnt != 0) begin
        out_if.ready <= 1'b0;
        stall_cnt    <= stall_cnt - 1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        stall_cnt    <= $urandom_range(0, 5);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_code(out_if.fp8_code);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Timeout: no handshake for %0d cycles", WatchdogLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_value(fp8q_pkg::value_t v);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.value_bits <= v;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_value(v);
  endtask

  task automatic drain_requests();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_format(fp8q_pkg::fmt_e f);
    drain_requests();
    repeat (4) @(posedge clk_i);
    cfg_if.valid         <= 1'b1;
    cfg_if.format_select <= f;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.fmt = f;
  endtask

  task automatic run_corners(fp8q_pkg::fmt_e f);
    write_format(f);
    foreach (CornerValues[i]) send_value(CornerValues[i]);
  endtask

  task automatic run_random(fp8q_pkg::fmt_e f, bit hold_midway);
    logic       sgn;
    logic [7:0] expo;
    logic [22:0] man;
    int         pick;
    fp8q_pkg::value_t v;
    write_format(f);
    for (int n = 0; n < PhaseItems; n++) begin
      if (hold_midway && n == PhaseItems / 2) drain_requests();
      sgn  = 1'($urandom_range(0, 1));
      man  = 23'($urandom);
      expo = 8'($urandom_range(101, 144));
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
      end else if (pick < 65) begin
        expo = 8'($urandom_range(0, 255));
      end else if (pick < 75) begin
        expo = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 2) == 0) man = '0;
      end else if (pick < 90) begin
        man = man | 23'h7C_0000;
      end else begin
        expo = '0;
        man  = $urandom_range(0, 1) ? 23'd0 : 23'h7F_FFFF;
      end
      v = {sgn, expo, man};
      send_value(v);
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    idle_en              = 1'b1;
    quiet_cycles         = 0;
    in_if.valid          = 1'b0;
    in_if.value_bits     = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.format_select = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_corners(fp8q_pkg::FMT_E4M3);
    run_corners(fp8q_pkg::FMT_E5M2);
    run_random(fp8q_pkg::FMT_E4M3, 1'b0);
    run_random(fp8q_pkg::FMT_E5M2, 1'b1);
    run_random(fp8q_pkg::FMT_E4M3, 1'b0);
    idle_en = 1'b0;
    run_random(fp8q_pkg::FMT_E5M2, 1'b0);

    drain_requests();
    repeat (8) @(posedge clk_i);

    $display("Converted %0d FP32 values to E4M3 and E5M2 (zeros, NaN, infinities,",
             sb.accepted);
    $display("overflow, rounding carry, FP8 subnormals); %0d codes checked, %0d mismatches",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
